[src/sky_cone_membership_test_top_defines.svh]
// assertion macros used by the checker file
`ifndef SKY_CONE_MEMBERSHIP_TEST_TOP_DEFINES_SVH
`define SKY_CONE_MEMBERSHIP_TEST_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SCM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scm check failed");

// antecedent implies consequent in the next cycle
`define SCM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scm check failed");

`endif

[src/scm_pkg.sv]
// constants and helpers for the sky cone membership test
`timescale 1ns / 1ps
package scm_pkg;

   localparam int ANGLE_FRAC_BITS = 16;

   localparam int RA_W   = 25;
   localparam int DEC_W  = 24;
   localparam int RAD_W  = 24;
   localparam int ARG_W  = 24;
   localparam int SIN_W  = 31;
   localparam int X_W    = 31;
   localparam int X2_W   = 32;
   localparam int AQ_W   = 51;
   localparam int W26_W  = 29;
   localparam int Q_W    = 30;
   localparam int CSR_W  = 25;
   localparam int IDX_W  = 2;

   localparam logic [IDX_W-1:0] CSR_CENTER_RA   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_CENTER_DEC  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_CONE_RADIUS = 2'd2;

   localparam logic [RA_W-1:0]  FULL_TURN = RA_W'(360 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [RA_W-1:0]  HALF_TURN = RA_W'(180 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [DEC_W-1:0] DEC_LIM   = DEC_W'(90 * (2 ** ANGLE_FRAC_BITS));
   localparam logic [ARG_W-1:0] ARG_LIM   = ARG_W'(90 * (2 ** (ANGLE_FRAC_BITS + 1)));
   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(180 * (2 ** ANGLE_FRAC_BITS));

   // pi in q30 split as 45*q + r, the divisor being 45 * 2^(frac+3)
   localparam logic [26:0]      PI_DIV_Q  = 27'd74961320;
   localparam logic [4:0]       PI_DIV_R  = 5'd26;
   localparam int               DIV_SHIFT = ANGLE_FRAC_BITS + 3;
   localparam logic [AQ_W-1:0]  ROUND_Q   = AQ_W'(2 ** (ANGLE_FRAC_BITS + 2));
   localparam logic [23:0]      RECIP45   = 24'((64'd1 << 29) / 45);
   localparam logic [W26_W-1:0] DIV45     = W26_W'(45);

   localparam logic [SIN_W-1:0] ONE_Q30   = SIN_W'(2 ** 30);

   localparam int HORNER_N = 7;
   localparam int SIN_LAT  = 4 + 3 * HORNER_N + 1;
   localparam int RSP_LAT  = 2 + SIN_LAT + 3;

   function automatic logic [7:0] horner_den(input int k);
      logic [7:0] d;
      case (k)
         0:       d = 8'd210;
         1:       d = 8'd156;
         2:       d = 8'd110;
         3:       d = 8'd72;
         4:       d = 8'd42;
         5:       d = 8'd20;
         default: d = 8'd6;
      endcase
      return d;
   endfunction

   // floor(2^32 / d): quotient is then exact or one short
   function automatic logic [Q_W-1:0] horner_recip(input int k);
      logic [Q_W-1:0] r;
      case (k)
         0:       r = 30'd20452225;
         1:       r = 30'd27531841;
         2:       r = 30'd39045157;
         3:       r = 30'd59652323;
         4:       r = 30'd102261126;
         5:       r = 30'd214748364;
         default: r = 30'd715827882;
      endcase
      return r;
   endfunction

endpackage

[src/scm_sin.sv]
// pipelined fixed-point sine of an angle in half units, q30 result
`timescale 1ns / 1ps
module scm_sin
   import scm_pkg::*;
(
   input  logic             clock,
   input  logic [ARG_W-1:0] angle,
   output logic [SIN_W-1:0] sine
);

   logic [ARG_W-1:0]         angle_sat;
   logic [AQ_W-1:0]          aq_in, aq1_ff, aq2_ff;
   logic [W26_W-1:0]         w_in, w1_ff, w2_ff;
   logic [W26_W+ARG_W-1:0]   wm;
   logic [ARG_W-1:0]         q0_ff;
   logic [W26_W-1:0]         rem45;
   logic [AQ_W-1:0]          xsum;
   logic [X_W-1:0]           x3_ff, x4_ff;
   logic [2*X_W-1:0]         xsq;
   logic [X2_W-1:0]          x2_ff;

   logic [X2_W-1:0]  p_a_ff  [HORNER_N];
   logic [X2_W-1:0]  p_b_ff  [HORNER_N];
   logic [Q_W-1:0]   q_b_ff  [HORNER_N];
   logic [SIN_W-1:0] t_c_ff  [HORNER_N];
   logic [X_W-1:0]   x_a_ff  [HORNER_N];
   logic [X_W-1:0]   x_b_ff  [HORNER_N];
   logic [X_W-1:0]   x_c_ff  [HORNER_N];
   logic [X2_W-1:0]  x2_a_ff [HORNER_N];
   logic [X2_W-1:0]  x2_b_ff [HORNER_N];
   logic [X2_W-1:0]  x2_c_ff [HORNER_N];

   logic [X_W+SIN_W-1:0] sm;
   logic [X2_W-1:0]      sv;
   logic [SIN_W-1:0]     sine_in, sine_ff;

   // angle to radians: x = round(a * pi / (360 * 2^frac))
   assign angle_sat = (angle > ARG_LIM) ? ARG_LIM : angle;
   assign aq_in     = AQ_W'(angle_sat) * AQ_W'(PI_DIV_Q);
   assign w_in      = W26_W'(angle_sat) * W26_W'(PI_DIV_R);
   assign wm        = (W26_W+ARG_W)'(w1_ff) * (W26_W+ARG_W)'(RECIP45);
   assign rem45     = w2_ff - W26_W'(q0_ff) * DIV45;
   assign xsum      = aq2_ff + ROUND_Q + AQ_W'(q0_ff) + AQ_W'(rem45 >= DIV45);
   assign xsq       = (2*X_W)'(x3_ff) * (2*X_W)'(x3_ff);

   always_ff @(posedge clock) begin
      aq1_ff <= aq_in;
      w1_ff  <= w_in;
      aq2_ff <= aq1_ff;
      w2_ff  <= w1_ff;
      q0_ff  <= wm[W26_W +: ARG_W];
      x3_ff  <= xsum[DIV_SHIFT +: X_W];
      x4_ff  <= x3_ff;
      x2_ff  <= xsq[30 +: X2_W];
   end

   // horner steps: multiply, reciprocal multiply, correct and subtract
   for (genvar k = 0; k < HORNER_N; k++) begin : g_step
      logic [SIN_W-1:0]       t_src;
      logic [X_W-1:0]         x_src;
      logic [X2_W-1:0]        x2_src;
      logic [X2_W+SIN_W-1:0]  pm;
      logic [X2_W+Q_W-1:0]    qm;
      logic [X2_W-1:0]        rem;
      logic [Q_W-1:0]         qfix;

      if (k == 0) begin : g_first
         assign t_src  = ONE_Q30;
         assign x_src  = x4_ff;
         assign x2_src = x2_ff;
      end else begin : g_next
         assign t_src  = t_c_ff[k-1];
         assign x_src  = x_c_ff[k-1];
         assign x2_src = x2_c_ff[k-1];
      end

      assign pm   = (X2_W+SIN_W)'(x2_src) * (X2_W+SIN_W)'(t_src);
      assign qm   = (X2_W+Q_W)'(p_a_ff[k]) * (X2_W+Q_W)'(horner_recip(k));
      assign rem  = p_b_ff[k] - X2_W'(q_b_ff[k]) * X2_W'(horner_den(k));
      assign qfix = q_b_ff[k] + Q_W'(rem >= X2_W'(horner_den(k)));

      always_ff @(posedge clock) begin
         p_a_ff[k]  <= pm[30 +: X2_W];
         x_a_ff[k]  <= x_src;
         x2_a_ff[k] <= x2_src;
         p_b_ff[k]  <= p_a_ff[k];
         q_b_ff[k]  <= qm[32 +: Q_W];
         x_b_ff[k]  <= x_a_ff[k];
         x2_b_ff[k] <= x2_a_ff[k];
         t_c_ff[k]  <= ONE_Q30 - SIN_W'(qfix);
         x_c_ff[k]  <= x_b_ff[k];
         x2_c_ff[k] <= x2_b_ff[k];
      end
   end

   assign sm      = (X_W+SIN_W)'(x_c_ff[HORNER_N-1]) * (X_W+SIN_W)'(t_c_ff[HORNER_N-1]);
   assign sv      = sm[30 +: X2_W];
   assign sine_in = (sv > X2_W'(ONE_Q30)) ? ONE_Q30 : sv[SIN_W-1:0];

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

[src/sky_cone_membership_test_top.sv]
// top level of the sky cone membership test
`timescale 1ns / 1ps
// Decides whether an event direction lies within a cone on the sky.
// Request channel: start with req_event_ra, req_event_dec and
// req_position_present; a request is taken at a rising edge with start high
// and busy low. busy is high only while reset is held, so a request can be
// taken on every cycle.
// Result channel: rsp_valid is high for one cycle with rsp_accepted; results
// come out in request order, one per cycle at full rate. The path runs through
// the sine pipelines: a 4-stage angle scaling front, seven Horner steps of three
// stages each and a final product, plus two stages of range reduction before and
// three of squares after.
// The receiver has no way to stall, so nothing holds the pipeline.
// Config: csr_write with csr_index (0 centre ra, 1 centre dec, 2 radius) and
// csr_wdata; write only with no request in flight. Radius of 180 degrees or
// more accepts everything; so does a request without a position.
// Reset: synchronous; clears the in-flight valid bits and sets the centre to
// zero and the radius to 180 degrees.
module sky_cone_membership_test_top
   import scm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic        [RA_W-1:0]  req_event_ra,
   input  logic signed [DEC_W-1:0] req_event_dec,
   input  logic                    req_position_present,
   output logic                    rsp_valid,
   output logic                    rsp_accepted,
   input  logic                    csr_write,
   input  logic        [IDX_W-1:0] csr_index,
   input  logic        [CSR_W-1:0] csr_wdata
);

   logic [RA_W-1:0]         center_ra_ff;
   logic signed [DEC_W-1:0] center_dec_ff;
   logic [RAD_W-1:0]        cone_radius_ff;

   logic                    take;
   logic signed [DEC_W-1:0] dec_e_in, dec_c_in;
   logic                    v1_ff, byp1_ff;
   logic [RA_W-1:0]         ra_e1_ff, ra_c1_ff;
   logic signed [DEC_W-1:0] dec_e1_ff, dec_c1_ff;
   logic [RAD_W-1:0]        rad1_ff;

   logic [RA_W-1:0]         dra_raw, dra_in;
   logic signed [DEC_W:0]   ddec;
   logic [DEC_W:0]          ddec_mag;
   logic [DEC_W-1:0]        mag_e, mag_c;
   logic                    v2_ff, byp2_ff;
   logic [ARG_W-1:0]        sd_arg_ff, sa_arg_ff, ce_arg_ff, cc_arg_ff, sr_arg_ff;

   logic [SIN_W-1:0]        sd, sa, ce, cc, sr;
   logic                    v_s_ff   [SIN_LAT];
   logic                    byp_s_ff [SIN_LAT];

   logic [2*SIN_W-1:0]      sd_sq, sa_sq, cecc_m, sr_sq;
   logic                    v3_ff, byp3_ff, v4_ff, byp4_ff;
   logic [SIN_W-1:0]        sd2_ff, sa2_ff, cecc_ff, lim3_ff, sd2b_ff, lim4_ff;
   logic [2*SIN_W-1:0]      prod_m;
   logic [SIN_W-1:0]        prod_ff;
   logic [X2_W-1:0]         hav;
   logic                    rsp_valid_ff, rsp_accepted_ff;

   assign busy = reset;
   assign take = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ra_ff   <= '0;
         center_dec_ff  <= '0;
         cone_radius_ff <= RADIUS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CENTER_RA:   center_ra_ff   <= csr_wdata[RA_W-1:0];
            CSR_CENTER_DEC:  center_dec_ff  <= csr_wdata[DEC_W-1:0];
            CSR_CONE_RADIUS: cone_radius_ff <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: wrap ra into one turn, saturate declinations
   assign dec_e_in = (req_event_dec > $signed(DEC_LIM))  ? $signed(DEC_LIM) :
                     (req_event_dec < -$signed(DEC_LIM)) ? -$signed(DEC_LIM) : req_event_dec;
   assign dec_c_in = (center_dec_ff > $signed(DEC_LIM))  ? $signed(DEC_LIM) :
                     (center_dec_ff < -$signed(DEC_LIM)) ? -$signed(DEC_LIM) : center_dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= take;
      end
      byp1_ff   <= !req_position_present || (RA_W'(cone_radius_ff) >= HALF_TURN);
      ra_e1_ff  <= (req_event_ra >= FULL_TURN) ? req_event_ra - FULL_TURN : req_event_ra;
      ra_c1_ff  <= (center_ra_ff >= FULL_TURN) ? center_ra_ff - FULL_TURN : center_ra_ff;
      dec_e1_ff <= dec_e_in;
      dec_c1_ff <= dec_c_in;
      rad1_ff   <= cone_radius_ff;
   end

   // stage 2: shorter ra difference, dec difference, sine arguments
   assign dra_raw  = (ra_e1_ff >= ra_c1_ff) ? ra_e1_ff - ra_c1_ff
                                           : ra_e1_ff + FULL_TURN - ra_c1_ff;
   assign dra_in   = (dra_raw > HALF_TURN) ? FULL_TURN - dra_raw : dra_raw;
   assign ddec     = {dec_e1_ff[DEC_W-1], dec_e1_ff} - {dec_c1_ff[DEC_W-1], dec_c1_ff};
   assign ddec_mag = ddec[DEC_W] ? (DEC_W+1)'(0) - ddec : ddec;
   assign mag_e    = dec_e1_ff[DEC_W-1] ? -dec_e1_ff : dec_e1_ff;
   assign mag_c    = dec_c1_ff[DEC_W-1] ? -dec_c1_ff : dec_c1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      byp2_ff   <= byp1_ff;
      sd_arg_ff <= ddec_mag[ARG_W-1:0];
      sa_arg_ff <= dra_in[ARG_W-1:0];
      ce_arg_ff <= ARG_W'({DEC_LIM - mag_e, 1'b0});
      cc_arg_ff <= ARG_W'({DEC_LIM - mag_c, 1'b0});
      sr_arg_ff <= rad1_ff;
   end

   scm_sin u_sin_sd (.clock(clock), .angle(sd_arg_ff), .sine(sd));
   scm_sin u_sin_sa (.clock(clock), .angle(sa_arg_ff), .sine(sa));
   scm_sin u_sin_ce (.clock(clock), .angle(ce_arg_ff), .sine(ce));
   scm_sin u_sin_cc (.clock(clock), .angle(cc_arg_ff), .sine(cc));
   scm_sin u_sin_sr (.clock(clock), .angle(sr_arg_ff), .sine(sr));

   // valid and bypass flags ride alongside the sine pipelines
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIN_LAT; i++) begin
            v_s_ff[i] <= 1'b0;
         end
      end else begin
         v_s_ff[0] <= v2_ff;
         for (int i = 1; i < SIN_LAT; i++) begin
            v_s_ff[i] <= v_s_ff[i-1];
         end
      end
      byp_s_ff[0] <= byp2_ff;
      for (int i = 1; i < SIN_LAT; i++) begin
         byp_s_ff[i] <= byp_s_ff[i-1];
      end
   end

   // squares and products, each truncated back to q30
   assign sd_sq  = (2*SIN_W)'(sd) * (2*SIN_W)'(sd);
   assign sa_sq  = (2*SIN_W)'(sa) * (2*SIN_W)'(sa);
   assign cecc_m = (2*SIN_W)'(ce) * (2*SIN_W)'(cc);
   assign sr_sq  = (2*SIN_W)'(sr) * (2*SIN_W)'(sr);
   assign prod_m = (2*SIN_W)'(cecc_ff) * (2*SIN_W)'(sa2_ff);
   assign hav    = X2_W'(sd2b_ff) + X2_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v3_ff        <= v_s_ff[SIN_LAT-1];
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
      byp3_ff         <= byp_s_ff[SIN_LAT-1];
      sd2_ff          <= sd_sq[30 +: SIN_W];
      sa2_ff          <= sa_sq[30 +: SIN_W];
      cecc_ff         <= cecc_m[30 +: SIN_W];
      lim3_ff         <= sr_sq[30 +: SIN_W];
      byp4_ff         <= byp3_ff;
      sd2b_ff         <= sd2_ff;
      lim4_ff         <= lim3_ff;
      prod_ff         <= prod_m[30 +: SIN_W];
      rsp_accepted_ff <= byp4_ff || (hav <= X2_W'(lim4_ff));
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

endmodule

[src/scm_checker.sv]
// port-level checks for the sky cone membership test, bound to the top level
`timescale 1ns / 1ps
`include "sky_cone_membership_test_top_defines.svh"
module scm_checker
   import scm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_position_present,
   input logic rsp_valid,
   input logic rsp_accepted
);

   // every result traces back to an earlier taken request
   `SCM_ASSERT_SAME(a_rsp_has_request, rsp_valid, $past(start && !busy, RSP_LAT))

   // a request taken now brings a result after the pipeline latency
   `SCM_ASSERT_SAME(a_request_has_rsp, $past(start && !busy, RSP_LAT) && !$past(reset, RSP_LAT - 1), rsp_valid || $past(reset, RSP_LAT - 2))

   // a request with no position is always accepted
   `SCM_ASSERT_SAME(a_no_position_accepts, rsp_valid && $past(!req_position_present, RSP_LAT), rsp_accepted)

   // busy only follows reset
   `SCM_ASSERT_NEXT(a_busy_clears, 1'b1, !busy)

endmodule

bind sky_cone_membership_test_top scm_checker u_scm_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_position_present (req_position_present),
   .rsp_valid            (rsp_valid),
   .rsp_accepted         (rsp_accepted)
);

[tb/sky_cone_membership_test_top_test.sv]
// self-checking testbench for the sky cone membership test
`timescale 1ns / 1ps
module sky_cone_membership_test_top_test;
   import scm_pkg::*;

   typedef struct packed {
      logic [RA_W-1:0]  ra;
      logic [DEC_W-1:0] dec;
      logic             present;
   } cone_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [RA_W-1:0] req_event_ra = '0;
   logic signed [DEC_W-1:0] req_event_dec = '0;
   logic req_position_present = 1'b0;
   logic rsp_valid;
   logic rsp_accepted;
   logic csr_write = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   cone_req_type pending_reqs[$];
   logic         expected_accepts[$];
   int           sender_idle_pct = 0;
   int           fail_count = 0;

   // predictor's copy of the registers
   longint unsigned pred_center_ra = 0;
   longint          pred_center_dec = 0;
   longint unsigned pred_radius = 180 << 16;

   localparam longint unsigned Q30 = 64'd1 << 30;
   localparam longint unsigned PI_Q = 64'd3373259426;

   sky_cone_membership_test_top uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint sign_ext24(longint unsigned v);
      v &= 64'hFFFFFF;
      return v[23] ? longint'(v) - 64'h1000000 : longint'(v);
   endfunction

   function automatic longint clip_dec(longint d);
      longint lim = 90 << 16;
      return d > lim ? lim : (d < -lim ? -lim : d);
   endfunction

   // sine of angle in half-units of the angle lsb, q30
   function automatic longint unsigned half_sine(longint unsigned a);
      longint unsigned den = 360 << 16;
      longint unsigned x, x2, t, s;
      longint unsigned dens[7] = '{210, 156, 110, 72, 42, 20, 6};
      if (a > (90 << 17)) a = 90 << 17;
      x = (a * PI_Q + den / 2) / den;
      x2 = (x * x) >> 30;
      t = Q30;
      for (int k = 0; k < 7; k++) t = Q30 - ((x2 * t) >> 30) / dens[k];
      s = (x * t) >> 30;
      return s > Q30 ? Q30 : s;
   endfunction

   function automatic logic in_cone(cone_req_type r);
      longint unsigned full = 360 << 16, half = 180 << 16;
      longint unsigned rae, rac, dra, sd, sa, ce, cc, sr, hav, lim;
      longint de, dc, dd;
      if (!r.present || pred_radius >= half) return 1'b1;
      rae = longint'(r.ra) % full;
      rac = pred_center_ra % full;
      dra = rae >= rac ? rae - rac : rae + full - rac;
      if (dra > half) dra = full - dra;
      de = clip_dec(sign_ext24(r.dec));
      dc = clip_dec(pred_center_dec);
      dd = de - dc;
      sd = half_sine(dd < 0 ? -dd : dd);
      sa = half_sine(dra);
      ce = half_sine(((90 << 16) - (de < 0 ? -de : de)) * 2);
      cc = half_sine(((90 << 16) - (dc < 0 ? -dc : dc)) * 2);
      sr = half_sine(pred_radius);
      hav = ((sd * sd) >> 30) + ((((ce * cc) >> 30) * ((sa * sa) >> 30)) >> 30);
      lim = (sr * sr) >> 30;
      return hav <= lim;
   endfunction

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_CENTER_RA:   pred_center_ra = val;
         CSR_CENTER_DEC:  pred_center_dec = sign_ext24(val);
         CSR_CONE_RADIUS: pred_radius = val & 25'hFFFFFF;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || start || expected_accepts.size() != 0)
         @(posedge clock);
   endtask

   task automatic drain();
      wait_idle();
      repeat (RSP_LAT + 5) @(posedge clock);
   endtask

   function automatic cone_req_type rand_req(bit near);
      cone_req_type r;
      longint d;
      r.present = ($urandom_range(0, 9) != 0);
      if (near) begin
         // keep events close to the centre so both outcomes occur
         r.ra = RA_W'((pred_center_ra + $urandom_range(0, 40 << 16)
                       + (360 << 16) - (20 << 16)) % (360 << 16));
         d = clip_dec(pred_center_dec) + longint'($urandom_range(0, 40 << 16)) - (20 << 16);
         r.dec = DEC_W'(d);
      end else begin
         r.ra = RA_W'($urandom);
         r.dec = DEC_W'($urandom);
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            cone_req_type r;
            r = pending_reqs.pop_front();
            expected_accepts.push_back(in_cone(r));
            req_event_ra <= r.ra;
            req_event_dec <= r.dec;
            req_position_present <= r.present;
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_reqs.size() > 0
                   && $urandom_range(0, 99) >= sender_idle_pct) begin
         cone_req_type r;
         r = pending_reqs.pop_front();
         expected_accepts.push_back(in_cone(r));
         start <= 1'b1;
         req_event_ra <= r.ra;
         req_event_dec <= r.dec;
         req_position_present <= r.present;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_accepts.size() == 0) begin
            $error("unexpected result: accepted=%0b", rsp_accepted);
            fail_count++;
         end else begin
            logic exp_acc;
            exp_acc = expected_accepts.pop_front();
            if (rsp_accepted !== exp_acc) begin
               $error("accepted: expected %0b actual %0b", exp_acc, rsp_accepted);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("sky_cone_membership_test_top regression: fail");
      $finish;
   end

   initial begin
      cone_req_type r;
      int idle_pcts[4] = '{0, 75, 0, 38};
      logic [CSR_W-1:0] radii[6] = '{0, 1, 5 << 16, 30 << 16, 179 << 16, 180 << 16};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: reset radius accepts all, tried with field extremes
      r = '{ra: '1, dec: 24'h800000, present: 1'b1}; pending_reqs.push_back(r);
      r = '{ra: '0, dec: 24'h7FFFFF, present: 1'b0}; pending_reqs.push_back(r);
      drain();
      write_reg(CSR_CENTER_RA, 25'd0);
      write_reg(CSR_CENTER_DEC, 25'd0);
      write_reg(CSR_CONE_RADIUS, 25'd0);
      r = '{ra: 0, dec: 0, present: 1'b1}; pending_reqs.push_back(r);         // exact hit
      r = '{ra: 360 << 16, dec: 0, present: 1'b1}; pending_reqs.push_back(r); // ra wraps
      r = '{ra: 1, dec: 0, present: 1'b1}; pending_reqs.push_back(r);
      r = '{ra: '1, dec: '1, present: 1'b0}; pending_reqs.push_back(r);
      drain();
      write_reg(CSR_CENTER_RA, 25'd23592959);
      write_reg(CSR_CENTER_DEC, 25'(24'sd5898240));
      write_reg(CSR_CONE_RADIUS, 25'd10 << 16);
      r = '{ra: 5 << 16, dec: 24'h7FFFFF, present: 1'b1}; pending_reqs.push_back(r); // pole
      r = '{ra: 200 << 16, dec: 85 << 16, present: 1'b1}; pending_reqs.push_back(r);
      r = '{ra: 10 << 16, dec: 24'h800000, present: 1'b1}; pending_reqs.push_back(r);
      r = '{ra: 359 << 16, dec: 82 << 16, present: 1'b1}; pending_reqs.push_back(r);
      drain();
      write_reg(CSR_CENTER_RA, 25'd10 << 16);
      write_reg(CSR_CENTER_DEC, 25'(-24'sd5898240));
      write_reg(2'd3, 25'h1FFFFFF); // unused index
      r = '{ra: 350 << 16, dec: -(85 << 16), present: 1'b1}; pending_reqs.push_back(r);
      r = '{ra: 200 << 16, dec: 24'h800000, present: 1'b1}; pending_reqs.push_back(r);
      drain();
      for (int ph = 0; ph < 12; ph++) begin
         sender_idle_pct = idle_pcts[ph % 4];
         write_reg(CSR_CENTER_RA, ph == 11 ? 25'h1FFFFFF : 25'($urandom_range(0, 23592959)));
         write_reg(CSR_CENTER_DEC, 25'(24'($urandom_range(0, 11796480) - 5898240)));
         write_reg(CSR_CONE_RADIUS, ph == 10 ? 25'hFFFFFF : radii[ph % 6]);
         for (int i = 0; i < 95; i++) begin
            pending_reqs.push_back(rand_req($urandom_range(0, 3) != 0));
            // pause once until everything in flight has come back
            if (ph == 5 && i == 40) begin
               wait_idle();
            end
         end
         drain();
      end
      if (fail_count == 0)
         $display("sky_cone_membership_test_top regression: pass");
      else
         $display("sky_cone_membership_test_top regression: fail");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/scm_pkg.sv
src/scm_sin.sv
src/sky_cone_membership_test_top.sv
src/scm_checker.sv
tb/sky_cone_membership_test_top_test.sv
